>>> sv/tpws_pkg.sv
// ----------------------------------------------------------------------------
// Text page and width scanner package
// Shared types and constants for the scanner core and its top level.
// ----------------------------------------------------------------------------
package tpws_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PAGE_W     = 25;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned EXPECT_W   = 24;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (PAGE_W + 2 * COUNT_W + WIDTH_W + 1);
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic KIND_PAGE  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF  = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

  typedef struct packed {
    logic               record_kind;
    logic [PAGE_W-1:0]  page_index;
    logic [COUNT_W-1:0] byte_offset;
    logic [COUNT_W-1:0] line_count;
    logic [WIDTH_W-1:0] widest_line;
    logic               pages_disagree;
    logic               last_of_run;
  } rec_t;

  typedef struct packed {
    logic pg_vld;
    logic fin_vld;
    rec_t pg;
    rec_t fin;
  } emit_t;

endpackage

>>> sv/tpws_core.sv
// ----------------------------------------------------------------------------
// Text page and width scanner core
// Holds the per-document counters and forms the page and final records for
// one byte.
// ----------------------------------------------------------------------------
module tpws_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              proc_en,
  input  logic [tpws_pkg::BYTE_W-1:0]       byte_value,
  input  logic                              end_of_document,
  input  logic [tpws_pkg::EXPECT_W-1:0]     expected_pages,
  output tpws_pkg::emit_t                   emit
);
  import tpws_pkg::*;

  logic [COUNT_W-1:0] offset_r, offset_nxt;
  logic [COUNT_W-1:0] lines_r, lines_nxt;
  logic [WIDTH_W-1:0] col_r, col_nxt;
  logic [WIDTH_W-1:0] maxw_r, maxw_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;

  logic [COUNT_W-1:0] offset_upd;
  logic [COUNT_W-1:0] lines_upd;
  logic [WIDTH_W-1:0] col_upd;
  logic [WIDTH_W-1:0] maxw_upd;
  logic [PAGE_W-1:0]  page_upd;
  logic [2:0]         bw;
  logic [6:0]         c7;
  logic               c7_print;
  logic [WIDTH_W:0]   col_sum;

  always_comb begin
    c7       = byte_value[6:0];
    c7_print = (c7 >= 7'h20) && (c7 <= 7'h7E);
    priority if (byte_value == CH_TAB) begin
      bw = 3'd4 - {1'b0, col_r[1:0]};
    end else if (byte_value == CH_CR) begin
      bw = 3'd0;
    end else if (byte_value == CH_FF) begin
      bw = 3'd2;
    end else if (byte_value[7]) begin
      bw = c7_print ? 3'd3 : 3'd4;
    end else begin
      bw = c7_print ? 3'd1 : 3'd2;
    end
    col_sum = {1'b0, col_r} + {{(WIDTH_W-2){1'b0}}, bw};
  end

  always_comb begin
    offset_upd = offset_r + 1'b1;
    lines_upd  = lines_r;
    maxw_upd   = maxw_r;
    page_upd   = page_r;
    col_upd    = col_sum[WIDTH_W] ? {WIDTH_W{1'b1}} : col_sum[WIDTH_W-1:0];
    if (byte_value == CH_LF) begin
      lines_upd = lines_r + 1'b1;
      maxw_upd  = (maxw_r < col_r) ? col_r : maxw_r;
      col_upd   = '0;
    end else if (byte_value == CH_FF) begin
      page_upd = page_r + 1'b1;
    end

    emit.pg_vld             = proc_en && (byte_value == CH_FF);
    emit.pg.record_kind     = KIND_PAGE;
    emit.pg.page_index      = page_r;
    emit.pg.byte_offset     = offset_r;
    emit.pg.line_count      = lines_r;
    emit.pg.widest_line     = '0;
    emit.pg.pages_disagree  = 1'b0;
    emit.pg.last_of_run     = !end_of_document;

    emit.fin_vld            = proc_en && end_of_document;
    emit.fin.record_kind    = KIND_FINAL;
    emit.fin.page_index     = page_upd;
    emit.fin.byte_offset    = offset_upd;
    emit.fin.line_count     = lines_upd;
    emit.fin.widest_line    = maxw_upd;
    emit.fin.pages_disagree = page_upd != {1'b0, expected_pages};
    emit.fin.last_of_run    = 1'b1;

    offset_nxt = offset_r;
    lines_nxt  = lines_r;
    col_nxt    = col_r;
    maxw_nxt   = maxw_r;
    page_nxt   = page_r;
    if (proc_en) begin
      if (end_of_document) begin
        offset_nxt = '0;
        lines_nxt  = '0;
        col_nxt    = '0;
        maxw_nxt   = '0;
        page_nxt   = {{(PAGE_W-1){1'b0}}, 1'b1};
      end else begin
        offset_nxt = offset_upd;
        lines_nxt  = lines_upd;
        col_nxt    = col_upd;
        maxw_nxt   = maxw_upd;
        page_nxt   = page_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      lines_r  <= '0;
      col_r    <= '0;
      maxw_r   <= '0;
      page_r   <= {{(PAGE_W-1){1'b0}}, 1'b1};
    end else begin
      offset_r <= offset_nxt;
      lines_r  <= lines_nxt;
      col_r    <= col_nxt;
      maxw_r   <= maxw_nxt;
      page_r   <= page_nxt;
    end
  end

endmodule

>>> sv/text_page_and_width_scanner_unit.sv
// ----------------------------------------------------------------------------
// Text page and width scanner unit
// Scans document bytes and emits page markers and end-of-document summaries.
// ----------------------------------------------------------------------------
// The unit accepts one document byte per clock cycle while its output queue
// keeps room for two records. A byte is captured in an input register and
// processed from there, which updates the counters and pushes zero, one or
// two records into a small output queue. A form feed that is also the last
// byte of a document yields two transactions, and since the queue drains one
// record per cycle while out_tready is high, a long run of such bytes fills
// the queue and holds back the input. The queue holds FIFO_DEPTH records
// and a byte is processed only while room for two is left.
module text_page_and_width_scanner_unit #(
  parameter int unsigned FIFO_DEPTH = tpws_pkg::FIFO_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] byte_value
  input  logic                               in_tlast,   // end_of_document
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [24:0] page_index, [56:25] byte_offset, [88:57] line_count,
  // [104:89] widest_line, [105] pages_disagree, [111:106] zero
  output logic [tpws_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser,  // record_kind
  output logic                               out_tlast,  // last_of_run
  input  logic                               cfg_wr_en,
  input  logic [tpws_pkg::EXPECT_W-1:0]      cfg_wr_data // expected_pages
);
  import tpws_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);

  logic [EXPECT_W-1:0] expect_r;
  logic                s1_vld_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                s1_last_r;
  logic                s1_fire;
  emit_t               emit;

  rec_t                fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PTR_W-1:0]    wr_ptr_p1;
  logic [PTR_W-1:0]    fin_ptr;
  logic                pop;
  rec_t                head;

  assign s1_fire   = s1_vld_r && (cnt_r <= ROOM_LIMIT);
  assign in_tready = !s1_vld_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= '0;
    end else if (cfg_wr_en) begin
      expect_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  tpws_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .proc_en         (s1_fire),
    .byte_value      (s1_byte_r),
    .end_of_document (s1_last_r),
    .expected_pages  (expect_r),
    .emit            (emit)
  );

  always_comb begin
    wr_ptr_p1  = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    fin_ptr    = emit.pg_vld ? wr_ptr_p1 : wr_ptr_r;
    pop        = out_tvalid && out_tready;
    rd_ptr_nxt = pop ? ((rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    wr_ptr_nxt = fin_ptr;
    if (emit.fin_vld) begin
      wr_ptr_nxt = (fin_ptr == PTR_LAST) ? '0 : fin_ptr + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(emit.pg_vld) + CNT_W'(emit.fin_vld) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.pg_vld) begin
      fifo_mem[wr_ptr_r] <= emit.pg;
    end
    if (emit.fin_vld) begin
      fifo_mem[fin_ptr] <= emit.fin;
    end
  end

  assign head       = fifo_mem[rd_ptr_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tuser  = head.record_kind;
  assign out_tlast  = head.last_of_run;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, head.pages_disagree, head.widest_line,
                       head.line_count, head.byte_offset, head.page_index};

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("output queue count exceeds its depth");

  a_final_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FINAL) |-> out_tlast)
    else $error("final record without last_of_run");

  a_page_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_PAGE) |-> (out_tdata[105:89] == '0))
    else $error("page record carries width or mismatch");

  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |-> cnt_r <= ROOM_LIMIT)
    else $error("byte processed without queue room");

endmodule
